// ===== hw/rtl/fsge_pkg.sv =====
// shared types, codes and controller/datapath interface structs for the sand grid engine
package fsge_pkg;

	localparam int KIND_W  = 2;
	localparam int COLOR_W = 32;
	localparam int CNT_W   = 13;
	localparam int WORD_W  = KIND_W + COLOR_W;
	localparam int COORD_W = 6;
	localparam int IN_W    = 48;
	localparam int OUT_W   = 48;

	localparam logic [KIND_W-1:0] KIND_AIR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SAND = 2'd1;

	localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;

	typedef enum logic [1:0] {
		CMD_PAINT = 2'd0,
		CMD_BRUSH = 2'd1,
		CMD_STEP  = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		WR_CLEAR  = 2'd0,
		WR_PAINT  = 2'd1,
		WR_TARGET = 2'd2,
		WR_SOURCE = 2'd3
	} wsel_t;

	typedef enum logic [1:0] {
		RD_POINT = 2'd0,
		RD_SCAN  = 2'd1,
		RD_NB    = 2'd2
	} rsel_t;

	localparam logic [1:0] NB_BELOW = 2'd0;
	localparam logic [1:0] NB_LEFT  = 2'd1;
	localparam logic [1:0] NB_RIGHT = 2'd2;

	typedef struct packed {
		logic  cap;
		logic  ram_we;
		wsel_t wsel;
		rsel_t rsel;
		logic  arm_inc;
		logic  nb_first;
		logic  nb_next;
		logic  scan_adv;
		logic  cnt_inc;
		logic  grab_color;
		logic  rd_capture;
		logic  out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		cmd_t in_cmd;
		logic last_cell;
		logic arm_last;
		logic pt_inside;
		logic cur_sand;
		logic row_nz;
		logic nb_air;
		logic nb_more;
		logic out_free;
	} ctrl_sts_t;

endpackage

// ===== hw/rtl/falling_sand_grid_engine.sv =====
// top level of the falling sand grid engine: controller, datapath and ports
// physics step: grid ram accessed through a single write and a single read port
// one item in flight; the next transfer is taken while a result still waits
// after reset a clearing pass writes air to all GRID_WIDTH*GRID_HEIGHT cells, one a cycle
module falling_sand_grid_engine import fsge_pkg::*; #(
	parameter int GRID_WIDTH  = 64,
	parameter int GRID_HEIGHT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_W-1:0]    s_tdata,   // cmd, col, row, cell_type, paint_color
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata,   // read_type, read_color, moved_count
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [COLOR_W-1:0] cfg_data
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	assign cfg_ready = 1'b1;

	fsge_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	fsge_dp #(
		.GRID_WIDTH (GRID_WIDTH),
		.GRID_HEIGHT(GRID_HEIGHT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data)
	);

endmodule

// ===== hw/rtl/fsge_ram.sv =====
// generic single-write, single-read ram with registered read data
module fsge_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/fsge_dp.sv =====
// datapath: item registers, scan counters, neighbour addressing, grid ram and result register
module fsge_dp import fsge_pkg::*; #(
	parameter int GRID_WIDTH  = 64,
	parameter int GRID_HEIGHT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_cmd_t          cmd,
	output ctrl_sts_t          sts,
	input  logic [IN_W-1:0]    s_tdata,
	input  logic               m_tready,
	output logic               m_tvalid,
	output logic [OUT_W-1:0]   m_tdata,
	input  logic               cfg_valid,
	input  logic [COLOR_W-1:0] cfg_data
);

	localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
	localparam int IDX_W  = $clog2(CELLS);
	localparam int CW     = $clog2(GRID_WIDTH);
	localparam int RW     = $clog2(GRID_HEIGHT);
	localparam logic [IDX_W-1:0] ROW_STEP = IDX_W'(GRID_WIDTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELLS - 1);
	localparam logic [CW-1:0]    LAST_COL = CW'(GRID_WIDTH - 1);
	localparam logic [RW-1:0]    LAST_ROW = RW'(GRID_HEIGHT - 1);

	// captured item
	cmd_t               cmd_q;
	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;
	logic [KIND_W-1:0]  kind_q;
	logic [COLOR_W-1:0] color_q;
	logic [COLOR_W-1:0] empty_color_q;

	// scan and sequencing state
	logic [IDX_W-1:0] k_q;
	logic [CW-1:0]    cc_q;
	logic [RW-1:0]    rr_q;
	logic [2:0]       arm_q;
	logic [1:0]       nb_q;
	logic [CNT_W-1:0] cnt_q;
	logic [COLOR_W-1:0] grain_color_q;

	// result and output register
	logic [KIND_W-1:0]  res_kind_q;
	logic [COLOR_W-1:0] res_color_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;

	// point addressing
	logic signed [7:0] pc;
	logic signed [7:0] pr;
	logic signed [1:0] off_c;
	logic signed [1:0] off_r;
	logic              pt_inside;
	logic [IDX_W-1:0]  pt_addr;
	logic [IDX_W-1:0]  nb_addr;
	logic              nb_more;
	logic [1:0]        nb_nxt;

	// ram ports
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	logic [WORD_W-1:0] ram_rdata;
	logic [KIND_W-1:0] rd_kind;

	assign rd_kind = ram_rdata[WORD_W-1 -: KIND_W];

	// brush arms: above, left, centre, right, below
	always_comb begin
		off_c = 2'sd0;
		off_r = 2'sd0;
		if (cmd_q == CMD_BRUSH) begin
			case (arm_q)
				3'd0: off_r = 2'sd1;
				3'd1: off_c = -2'sd1;
				3'd3: off_c = 2'sd1;
				3'd4: off_r = -2'sd1;
				default: begin
					off_c = 2'sd0;
					off_r = 2'sd0;
				end
			endcase
		end
	end

	assign pc = $signed({2'b00, col_q}) + 8'(off_c);
	assign pr = $signed({2'b00, row_q}) + 8'(off_r);

	assign pt_inside = !pc[7] && !pr[7]
		&& ({25'd0, pc[6:0]} < 32'(GRID_WIDTH))
		&& ({25'd0, pr[6:0]} < 32'(GRID_HEIGHT));
	assign pt_addr = IDX_W'({25'd0, pc[6:0]} + 32'(GRID_WIDTH) * {25'd0, pr[6:0]});

	always_comb begin
		case (nb_q)
			NB_LEFT:  nb_addr = k_q - ROW_STEP - IDX_W'(1);
			NB_RIGHT: nb_addr = k_q - ROW_STEP + IDX_W'(1);
			default:  nb_addr = k_q - ROW_STEP;
		endcase
	end

	always_comb begin
		nb_more = 1'b0;
		nb_nxt  = NB_RIGHT;
		case (nb_q)
			NB_BELOW: begin
				nb_more = (cc_q != '0) || (cc_q != LAST_COL);
				nb_nxt  = (cc_q != '0) ? NB_LEFT : NB_RIGHT;
			end
			NB_LEFT: begin
				nb_more = (cc_q != LAST_COL);
				nb_nxt  = NB_RIGHT;
			end
			default: begin
				nb_more = 1'b0;
				nb_nxt  = NB_RIGHT;
			end
		endcase
	end

	always_comb begin
		ram_we    = cmd.ram_we;
		ram_waddr = k_q;
		ram_wdata = '0;
		case (cmd.wsel)
			WR_CLEAR: begin
				ram_waddr = k_q;
				ram_wdata = '0;
			end
			WR_PAINT: begin
				ram_waddr = pt_addr;
				ram_wdata = {kind_q, color_q};
			end
			WR_TARGET: begin
				ram_waddr = nb_addr;
				ram_wdata = {KIND_SAND, grain_color_q};
			end
			default: begin
				ram_waddr = k_q;
				ram_wdata = {KIND_AIR, empty_color_q};
			end
		endcase
	end

	always_comb begin
		case (cmd.rsel)
			RD_POINT: ram_raddr = pt_addr;
			RD_NB:    ram_raddr = nb_addr;
			default:  ram_raddr = k_q;
		endcase
	end

	fsge_ram #(
		.WIDTH(WORD_W),
		.DEPTH(CELLS)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_color_q <= '0;
		end else if (cfg_valid) begin
			empty_color_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			cmd_q   <= cmd_t'(s_tdata[1:0]);
			col_q   <= s_tdata[7:2];
			row_q   <= s_tdata[13:8];
			kind_q  <= s_tdata[15:14];
			color_q <= s_tdata[47:16];
		end
		if (cmd.grab_color) begin
			grain_color_q <= ram_rdata[COLOR_W-1:0];
		end
		if (cmd.cap) begin
			res_kind_q  <= '0;
			res_color_q <= '0;
		end else if (cmd.rd_capture) begin
			res_kind_q  <= rd_kind;
			res_color_q <= ram_rdata[COLOR_W-1:0];
		end
		if (cmd.out_load) begin
			out_data_q <= {1'b0, cnt_q, res_color_q, res_kind_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			cc_q        <= '0;
			rr_q        <= '0;
			arm_q       <= '0;
			nb_q        <= NB_BELOW;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cap) begin
				k_q   <= '0;
				cc_q  <= '0;
				rr_q  <= '0;
				arm_q <= '0;
				cnt_q <= '0;
			end else begin
				if (cmd.scan_adv) begin
					k_q <= k_q + IDX_W'(1);
					if (cc_q == LAST_COL) begin
						cc_q <= '0;
						rr_q <= (rr_q == LAST_ROW) ? '0 : rr_q + RW'(1);
					end else begin
						cc_q <= cc_q + CW'(1);
					end
				end
				if (cmd.arm_inc) begin
					arm_q <= arm_q + 3'd1;
				end
				if (cmd.cnt_inc && (cnt_q != COUNT_MAX)) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (cmd.nb_first) begin
				nb_q <= NB_BELOW;
			end else if (cmd.nb_next) begin
				nb_q <= nb_nxt;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.in_cmd    = cmd_t'(s_tdata[1:0]);
	assign sts.last_cell = (k_q == LAST_IDX);
	assign sts.arm_last  = (arm_q == 3'd4);
	assign sts.pt_inside = pt_inside;
	assign sts.cur_sand  = (rd_kind == KIND_SAND);
	assign sts.row_nz    = (rr_q != '0);
	assign sts.nb_air    = (rd_kind == KIND_AIR);
	assign sts.nb_more   = nb_more;
	assign sts.out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== hw/rtl/fsge_ctrl.sv =====
// controller: sequences clearing, painting, reads and the physics scan
module fsge_ctrl import fsge_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);

	typedef enum logic [12:0] {
		S_CLEAR    = 13'b0000000000001,
		S_IDLE     = 13'b0000000000010,
		S_PAINT    = 13'b0000000000100,
		S_BRUSH    = 13'b0000000001000,
		S_RDREQ    = 13'b0000000010000,
		S_RDWAIT   = 13'b0000000100000,
		S_SCAN_RD  = 13'b0000001000000,
		S_SCAN_CHK = 13'b0000010000000,
		S_NB_RD    = 13'b0000100000000,
		S_NB_CHK   = 13'b0001000000000,
		S_MV_T     = 13'b0010000000000,
		S_MV_S     = 13'b0100000000000,
		S_DONE     = 13'b1000000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.wsel = WR_CLEAR;
		cmd.rsel = RD_SCAN;
		unique case (state_q)
			S_CLEAR: begin
				cmd.ram_we = 1'b1;
				cmd.wsel   = WR_CLEAR;
				if (sts.last_cell) begin
					state_d = S_IDLE;
				end else begin
					cmd.scan_adv = 1'b1;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.cap = 1'b1;
					unique case (sts.in_cmd)
						CMD_PAINT: state_d = S_PAINT;
						CMD_BRUSH: state_d = S_BRUSH;
						CMD_STEP:  state_d = S_SCAN_RD;
						CMD_READ:  state_d = S_RDREQ;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_PAINT: begin
				cmd.ram_we = sts.pt_inside;
				cmd.wsel   = WR_PAINT;
				state_d    = S_DONE;
			end
			S_BRUSH: begin
				cmd.ram_we  = sts.pt_inside;
				cmd.wsel    = WR_PAINT;
				cmd.arm_inc = 1'b1;
				if (sts.arm_last) begin
					state_d = S_DONE;
				end
			end
			S_RDREQ: begin
				cmd.rsel = RD_POINT;
				state_d  = sts.pt_inside ? S_RDWAIT : S_DONE;
			end
			S_RDWAIT: begin
				cmd.rd_capture = 1'b1;
				state_d        = S_DONE;
			end
			S_SCAN_RD: begin
				cmd.rsel = RD_SCAN;
				state_d  = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				cmd.grab_color = 1'b1;
				if (sts.cur_sand && sts.row_nz) begin
					cmd.nb_first = 1'b1;
					state_d      = S_NB_RD;
				end else if (sts.last_cell) begin
					state_d = S_DONE;
				end else begin
					cmd.scan_adv = 1'b1;
					state_d      = S_SCAN_RD;
				end
			end
			S_NB_RD: begin
				cmd.rsel = RD_NB;
				state_d  = S_NB_CHK;
			end
			S_NB_CHK: begin
				if (sts.nb_air) begin
					state_d = S_MV_T;
				end else if (sts.nb_more) begin
					cmd.nb_next = 1'b1;
					state_d     = S_NB_RD;
				end else if (sts.last_cell) begin
					state_d = S_DONE;
				end else begin
					cmd.scan_adv = 1'b1;
					state_d      = S_SCAN_RD;
				end
			end
			S_MV_T: begin
				cmd.ram_we  = 1'b1;
				cmd.wsel    = WR_TARGET;
				cmd.cnt_inc = 1'b1;
				state_d     = S_MV_S;
			end
			S_MV_S: begin
				cmd.ram_we = 1'b1;
				cmd.wsel   = WR_SOURCE;
				if (sts.last_cell) begin
					state_d = S_DONE;
				end else begin
					cmd.scan_adv = 1'b1;
					state_d      = S_SCAN_RD;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== tb/sv/tb_falling_sand_grid_engine.sv =====
// testbench for the sand grid engine: directed table, then random commands checked by a predictor
module tb_falling_sand_grid_engine;
	import fsge_pkg::*;

	localparam int GRID_W       = 64;
	localparam int GRID_H       = 64;
	localparam int CELLS        = GRID_W * GRID_H;
	localparam int RANDOM_ITEMS = 76;
	localparam int PHASE_ITEMS  = 25;
	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int QUIET_CYCLES = 20;
	localparam int PRINT_CAP    = 40;

	localparam logic [KIND_W-1:0] KIND_SOLID2 = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SOLID3 = 2'd3;

	typedef struct {
		logic [KIND_W-1:0]  kind;
		logic [COLOR_W-1:0] color;
		logic [CNT_W-1:0]   moved;
	} cell_report_t;

	typedef struct {
		bit                 set_blank;
		logic [COLOR_W-1:0] blank;
		cmd_t               op;
		int                 col;
		int                 row;
		logic [KIND_W-1:0]  kind;
		logic [COLOR_W-1:0] color;
		bit                 fixed;
		cell_report_t       want;
	} script_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_W-1:0]   m_tdata;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [COLOR_W-1:0] cfg_data;

	logic [KIND_W-1:0]  grid_kind [CELLS];
	logic [COLOR_W-1:0] grid_color [CELLS];
	logic [COLOR_W-1:0] blank_color;
	cell_report_t       awaited_reports [$];
	script_row_t        script [$];
	int                 errors;
	int                 cycles;
	int                 n_items;
	int                 n_steps;
	int                 n_moves;
	int                 n_reads;
	int                 n_blank_writes;
	bit                 calm;

	falling_sand_grid_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit is_inside(int c, int r);
		return c >= 0 && c < GRID_W && r >= 0 && r < GRID_H;
	endfunction

	function automatic bit is_open(int c, int r);
		return is_inside(c, r) && grid_kind[c + GRID_W * r] == KIND_AIR;
	endfunction

	function automatic void put_cell(int c, int r, logic [KIND_W-1:0] k,
			logic [COLOR_W-1:0] colr);
		if (is_inside(c, r)) begin
			grid_kind[c + GRID_W * r]  = k;
			grid_color[c + GRID_W * r] = colr;
		end
	endfunction

	// one pass in ascending index order; targets always sit below, so no grain moves twice
	function automatic logic [CNT_W-1:0] settle_grains();
		logic [CNT_W-1:0] moves;
		int k;
		int c;
		int r;
		int dest;
		moves = '0;
		for (k = 0; k < CELLS; k++) begin
			if (grid_kind[k] == KIND_SAND) begin
				c = k % GRID_W;
				r = k / GRID_W;
				if (is_open(c, r - 1)) begin
					dest = k - GRID_W;
				end else if (is_open(c - 1, r - 1)) begin
					dest = k - GRID_W - 1;
				end else if (is_open(c + 1, r - 1)) begin
					dest = k - GRID_W + 1;
				end else begin
					dest = -1;
				end
				if (dest >= 0) begin
					grid_kind[dest]  = KIND_SAND;
					grid_color[dest] = grid_color[k];
					grid_kind[k]     = KIND_AIR;
					grid_color[k]    = blank_color;
					if (moves != COUNT_MAX) begin
						moves++;
					end
				end
			end
		end
		return moves;
	endfunction

	function automatic cell_report_t run_command(cmd_t op, int c, int r,
			logic [KIND_W-1:0] k, logic [COLOR_W-1:0] colr);
		cell_report_t rep;
		rep.kind  = '0;
		rep.color = '0;
		rep.moved = '0;
		case (op)
			CMD_PAINT: begin
				put_cell(c, r, k, colr);
			end
			CMD_BRUSH: begin
				put_cell(c, r + 1, k, colr);
				put_cell(c - 1, r, k, colr);
				put_cell(c, r, k, colr);
				put_cell(c + 1, r, k, colr);
				put_cell(c, r - 1, k, colr);
			end
			CMD_STEP: begin
				rep.moved = settle_grains();
			end
			default: begin
				if (is_inside(c, r)) begin
					rep.kind  = grid_kind[c + GRID_W * r];
					rep.color = grid_color[c + GRID_W * r];
				end
			end
		endcase
		return rep;
	endfunction

	function automatic void plan(bit set_b, logic [COLOR_W-1:0] b, cmd_t op, int c, int r,
			logic [KIND_W-1:0] k, logic [COLOR_W-1:0] colr, bit fixed,
			logic [KIND_W-1:0] wk, logic [COLOR_W-1:0] wc, logic [CNT_W-1:0] wm);
		script_row_t row_item;
		row_item.set_blank  = set_b;
		row_item.blank      = b;
		row_item.op         = op;
		row_item.col        = c;
		row_item.row        = r;
		row_item.kind       = k;
		row_item.color      = colr;
		row_item.fixed      = fixed;
		row_item.want.kind  = wk;
		row_item.want.color = wc;
		row_item.want.moved = wm;
		script.push_back(row_item);
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		if (errors <= PRINT_CAP) begin
			$display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
		end
	endtask

	task automatic issue(cmd_t op, int c, int r, logic [KIND_W-1:0] k,
			logic [COLOR_W-1:0] colr, bit fixed, cell_report_t want);
		cell_report_t model;
		while (!calm && $urandom_range(99) < 7) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {colr, k, COORD_W'(r), COORD_W'(c), op};
		do @(posedge clk); while (!s_tready);
		model = run_command(op, c, r, k, colr);
		awaited_reports.push_back(fixed ? want : model);
		n_items++;
		if (op == CMD_STEP) begin
			n_steps++;
			n_moves += int'(model.moved);
		end
		if (op == CMD_READ) begin
			n_reads++;
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (awaited_reports.size() != 0) @(posedge clk);
	endtask

	task automatic write_blank(logic [COLOR_W-1:0] v);
		drain();
		repeat (QUIET_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		blank_color = v;
		n_blank_writes++;
	endtask

	always @(posedge clk) begin
		cell_report_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[falling_sand_grid_engine] ERROR");
			$finish;
		end else begin
			m_tready <= calm || $urandom_range(99) >= 7;
			if (arst_n && m_tvalid && m_tready) begin
				if (awaited_reports.size() == 0) begin
					report_mismatch("result with nothing outstanding", 64'(m_tdata), 64'd0);
				end else begin
					want = awaited_reports.pop_front();
					if (m_tdata[1:0] !== want.kind) begin
						report_mismatch("read_type", 64'(m_tdata[1:0]), 64'(want.kind));
					end
					if (m_tdata[33:2] !== want.color) begin
						report_mismatch("read_color", 64'(m_tdata[33:2]), 64'(want.color));
					end
					if (m_tdata[46:34] !== want.moved) begin
						report_mismatch("moved_count", 64'(m_tdata[46:34]),
							64'(want.moved));
					end
				end
			end
		end
	end

	initial begin
		cell_report_t none;
		int i;
		int j;
		int pick;
		int kpick;
		int c;
		int r;
		int last_c;
		int last_r;
		cmd_t op;
		logic [KIND_W-1:0] k;
		logic [COLOR_W-1:0] blank;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		calm      = 1'b0;
		none.kind  = '0;
		none.color = '0;
		none.moved = '0;
		blank_color = '0;
		for (i = 0; i < CELLS; i++) begin
			grid_kind[i]  = KIND_AIR;
			grid_color[i] = '0;
		end
		last_c = 0;
		last_r = 0;

		// cleared grid, corners, solids, edge brushes, air paint, blocked grain
		plan(0, 0, CMD_READ, 0, 0, KIND_AIR, 0, 1, KIND_AIR, 32'h0, 0);
		plan(0, 0, CMD_READ, 63, 63, KIND_AIR, 0, 1, KIND_AIR, 32'h0, 0);
		plan(0, 0, CMD_STEP, 0, 0, KIND_AIR, 0, 1, KIND_AIR, 32'h0, 0);
		plan(1, 32'hFFFF_FFFF, CMD_PAINT, 63, 63, KIND_SAND, 32'hAAAA_5555, 1, KIND_AIR, 0, 0);
		plan(0, 0, CMD_READ, 63, 63, KIND_AIR, 0, 1, KIND_SAND, 32'hAAAA_5555, 0);
		plan(0, 0, CMD_PAINT, 0, 0, KIND_SOLID2, 32'h0, 1, KIND_AIR, 0, 0);
		plan(0, 0, CMD_PAINT, 1, 0, KIND_SOLID3, 32'hFFFF_FFFF, 1, KIND_AIR, 0, 0);
		plan(0, 0, CMD_BRUSH, 0, 63, KIND_SAND, 32'h1234_5678, 1, KIND_AIR, 0, 0);
		plan(0, 0, CMD_BRUSH, 63, 0, KIND_SOLID3, 32'h8765_4321, 1, KIND_AIR, 0, 0);
		plan(0, 0, CMD_PAINT, 5, 5, KIND_AIR, 32'hDEAD_BEEF, 1, KIND_AIR, 0, 0);
		plan(0, 0, CMD_READ, 5, 5, KIND_AIR, 0, 1, KIND_AIR, 32'hDEAD_BEEF, 0);
		plan(0, 0, CMD_STEP, 0, 0, KIND_AIR, 0, 0, KIND_AIR, 0, 0);
		plan(0, 0, CMD_READ, 63, 62, KIND_AIR, 0, 0, KIND_AIR, 0, 0);
		plan(1, 32'h0, CMD_STEP, 0, 0, KIND_AIR, 0, 0, KIND_AIR, 0, 0);
		plan(0, 0, CMD_READ, 0, 63, KIND_AIR, 0, 0, KIND_AIR, 0, 0);
		plan(0, 0, CMD_BRUSH, 32, 32, KIND_SAND, 32'h0F0F_0F0F, 0, KIND_AIR, 0, 0);
		plan(0, 0, CMD_STEP, 0, 0, KIND_AIR, 0, 0, KIND_AIR, 0, 0);
		plan(0, 0, CMD_READ, 32, 31, KIND_AIR, 0, 0, KIND_AIR, 0, 0);
		plan(1, 32'h5A5A_A5A5, CMD_STEP, 0, 0, KIND_AIR, 0, 0, KIND_AIR, 0, 0);
		plan(0, 0, CMD_READ, 32, 32, KIND_AIR, 0, 0, KIND_AIR, 0, 0);
		plan(0, 0, CMD_PAINT, 0, 1, KIND_SAND, 32'hC0FF_EE00, 0, KIND_AIR, 0, 0);
		plan(0, 0, CMD_STEP, 0, 0, KIND_AIR, 0, 0, KIND_AIR, 0, 0);
		plan(0, 0, CMD_READ, 0, 1, KIND_AIR, 0, 0, KIND_AIR, 0, 0);
		plan(0, 0, CMD_READ, 5, 5, KIND_AIR, 0, 0, KIND_AIR, 0, 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (j = 0; j < script.size(); j++) begin
			if (script[j].set_blank) begin
				write_blank(script[j].blank);
			end
			issue(script[j].op, script[j].col, script[j].row, script[j].kind,
				script[j].color, script[j].fixed, script[j].want);
		end

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % PHASE_ITEMS == 0) begin
				case (i / PHASE_ITEMS)
					1:       blank = 32'h0;
					2:       blank = 32'hFFFF_FFFF;
					default: blank = $urandom;
				endcase
				write_blank(blank);
			end
			calm = (i >= 40 && i < 60);
			if ($urandom_range(19) == 0) begin
				drain();
			end
			pick = $urandom_range(99);
			if (pick < 30) begin
				op = CMD_PAINT;
			end else if (pick < 50) begin
				op = CMD_BRUSH;
			end else if (pick < 62) begin
				op = CMD_STEP;
			end else begin
				op = CMD_READ;
			end
			// about half the traffic in a small corner so grains pile up and slide
			if ($urandom_range(1)) begin
				c = $urandom_range(11);
				r = $urandom_range(11);
			end else begin
				c = $urandom_range(GRID_W - 1);
				r = $urandom_range(GRID_H - 1);
			end
			kpick = $urandom_range(99);
			if (kpick < 55) begin
				k = KIND_SAND;
			end else if (kpick < 70) begin
				k = KIND_AIR;
			end else if (kpick < 85) begin
				k = KIND_SOLID2;
			end else begin
				k = KIND_SOLID3;
			end
			if (op == CMD_READ && $urandom_range(1)) begin
				c = last_c;
				r = (last_r > 0 && $urandom_range(1)) ? last_r - 1 : last_r;
			end
			if (op == CMD_PAINT || op == CMD_BRUSH) begin
				last_c = c;
				last_r = r;
			end
			issue(op, c, r, k, $urandom, 0, none);
		end
		calm = 1'b0;

		drain();
		repeat (QUIET_CYCLES) @(posedge clk);
		$display("covered %0d commands: %0d physics steps moving %0d grains, %0d cell reads",
			n_items, n_steps, n_moves, n_reads);
		$display("empty colour register written %0d times, %0d mismatches", n_blank_writes,
			errors);
		if (errors == 0) begin
			$display("[falling_sand_grid_engine] OK");
		end else begin
			$display("[falling_sand_grid_engine] ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/fsge_pkg.sv
hw/rtl/fsge_ram.sv
hw/rtl/fsge_dp.sv
hw/rtl/fsge_ctrl.sv
hw/rtl/falling_sand_grid_engine.sv
tb/sv/tb_falling_sand_grid_engine.sv
